// File: hdl/ray_slope_box_overlap_test_top_macros.svh
// Assertion macros for the ray slope box test block.
`ifndef RAY_SLOPE_BOX_OVERLAP_TEST_TOP_MACROS_SVH
`define RAY_SLOPE_BOX_OVERLAP_TEST_TOP_MACROS_SVH

// Checked outside reset only.
`define RSBO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked in every cycle, reset included.
`define RSBO_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/rsbo_pkg.sv
// ---------------------------------------------------------------------------
// rsbo_pkg
// Shared types and constants of the ray slope box overlap test.
// ---------------------------------------------------------------------------
package rsbo_pkg;

  localparam int NUM_AXES  = 3;
  localparam int NUM_PAIRS = 6;
  localparam int NUM_REGS  = 7;
  localparam int EPS_W     = 16;
  localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;

  typedef enum logic [2:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_DIR_X    = 3'd3,
    REG_DIR_Y    = 3'd4,
    REG_DIR_Z    = 3'd5,
    REG_ZERO_EPS = 3'd6
  } reg_idx_t;

  // per-axis sign class: nonzero, negative
  typedef struct packed {
    logic nz;
    logic ng;
  } axis_class_t;

  // axis pairs (a,b): (x,y) (x,z) (y,x) (y,z) (z,x) (z,y)
  function automatic logic [1:0] pair_a(input logic [2:0] p);
    return p[2:1];
  endfunction

  function automatic logic [1:0] pair_b(input logic [2:0] p);
    logic [1:0] b;
    b = 2'd0;
    case (p)
      3'd0:    b = 2'd1;
      3'd1:    b = 2'd2;
      3'd2:    b = 2'd0;
      3'd3:    b = 2'd2;
      3'd4:    b = 2'd0;
      3'd5:    b = 2'd1;
      default: b = 2'd0;
    endcase
    return b;
  endfunction

endpackage

// File: hdl/rsbo_derive.sv
// ---------------------------------------------------------------------------
// rsbo_derive
// Rebuilds slopes, intercepts and the ray class from the ray registers,
// one axis pair at a time with a bit-serial divider and one multiplier.
// ---------------------------------------------------------------------------
module rsbo_derive #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start_i,
  input  logic signed [COORD_WIDTH-1:0]     origin_i [3],
  input  logic signed [COORD_WIDTH-1:0]     dir_i [3],
  input  logic [rsbo_pkg::EPS_W-1:0]        eps_i,
  output logic signed [COORD_WIDTH-1:0]     slope_o [6],
  output logic signed [COORD_WIDTH-1:0]     icpt_o [6],
  output rsbo_pkg::axis_class_t [2:0]       cls_o,
  output logic                              busy_o
);
  import rsbo_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int FB    = FRAC_BITS;
  localparam int NW    = CW + FB;
  localparam int IW    = 2 * CW + FB + 1;
  localparam int CNT_W = $clog2(NW);
  localparam int MW    = (CW > EPS_W) ? CW : EPS_W;

  localparam logic [NW-1:0] QMAX = {{(FB + 1){1'b0}}, {(CW - 1){1'b1}}};
  localparam logic [NW-1:0] QNEG = QMAX + NW'(1);
  localparam logic signed [CW-1:0] SMAX = {1'b0, {(CW - 1){1'b1}}};
  localparam logic signed [CW-1:0] SMIN = {1'b1, {(CW - 1){1'b0}}};

  typedef enum logic [2:0] {ST_IDLE, ST_SETUP, ST_DIV, ST_SAT, ST_MUL, ST_FIN} state_t;

  state_t                 state_r;
  logic [2:0]             pair_r;
  logic signed [CW-1:0]   src_o_r [3];
  logic signed [CW-1:0]   src_d_r [3];
  logic [EPS_W-1:0]       src_eps_r;
  logic [NW-1:0]          num_r;
  logic [NW-1:0]          q_r;
  logic [CW:0]            rem_r;
  logic [CW-1:0]          den_r;
  logic                   neg_r;
  logic [CNT_W-1:0]       cnt_r;
  logic signed [CW-1:0]   s_r;
  logic signed [2*CW-1:0] prod_r;
  logic signed [CW-1:0]   slope_r [6];
  logic signed [CW-1:0]   icpt_r [6];
  axis_class_t [2:0]      cls_r;

  function automatic logic [CW-1:0] mag(input logic signed [CW-1:0] v);
    return v[CW-1] ? (CW'(0) - v) : v;
  endfunction

  logic [1:0]             a_idx, b_idx;
  logic signed [CW-1:0]   da, db, oa, ob;
  logic [2:0]             zero_ax;
  axis_class_t [2:0]      cls_w;
  logic [CW:0]            rem_sh, rem_sub;
  logic                   ge;
  logic signed [CW-1:0]   s_sat;
  logic signed [2*CW-1:0] mul_w;
  logic signed [IW-1:0]   ob_w, pr_w, c_w, sh_w;
  logic                   fits;
  logic signed [CW-1:0]   icpt_val;

  assign a_idx = pair_a(pair_r);
  assign b_idx = pair_b(pair_r);
  assign da    = src_d_r[a_idx];
  assign db    = src_d_r[b_idx];
  assign oa    = src_o_r[a_idx];
  assign ob    = src_o_r[b_idx];

  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      zero_ax[k]  = (src_d_r[k] == '0) ||
                    (MW'(mag(src_d_r[k])) < MW'(src_eps_r));
      cls_w[k].nz = !zero_ax[k];
      cls_w[k].ng = !zero_ax[k] && src_d_r[k][CW-1];
    end
  end

  // restoring divide, one quotient bit a cycle
  assign rem_sh  = {rem_r[CW-1:0], num_r[NW-1]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_sub = rem_sh - {1'b0, den_r};

  always_comb begin
    if (neg_r) begin
      s_sat = (q_r > QNEG) ? SMIN : (CW'(0) - q_r[CW-1:0]);
    end else begin
      s_sat = (q_r > QMAX) ? SMAX : q_r[CW-1:0];
    end
  end

  assign mul_w = s_r * oa;

  // intercept: floor((ob << FB) - s*oa) >> FB, saturated
  assign ob_w     = IW'(ob);
  assign pr_w     = IW'(prod_r);
  assign c_w      = (ob_w <<< FB) - pr_w;
  assign sh_w     = c_w >>> FB;
  assign fits     = (&sh_w[IW-1:CW-1]) || !(|sh_w[IW-1:CW-1]);
  assign icpt_val = fits ? sh_w[CW-1:0] : (sh_w[IW-1] ? SMIN : SMAX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pair_r  <= '0;
      cls_r   <= '0;
      for (int p = 0; p < NUM_PAIRS; p++) begin
        slope_r[p] <= '0;
        icpt_r[p]  <= '0;
      end
    end else if (start_i) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        src_o_r[k] <= origin_i[k];
        src_d_r[k] <= dir_i[k];
      end
      src_eps_r <= eps_i;
      pair_r    <= '0;
      state_r   <= ST_SETUP;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
        end
        ST_SETUP: begin
          cls_r <= cls_w;
          if (zero_ax[a_idx]) begin
            s_r     <= '0;
            state_r <= ST_MUL;
          end else begin
            num_r   <= NW'(mag(db)) << FB;
            den_r   <= mag(da);
            rem_r   <= '0;
            q_r     <= '0;
            neg_r   <= da[CW-1] ^ db[CW-1];
            cnt_r   <= CNT_W'(NW - 1);
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_r <= ge ? rem_sub : rem_sh;
          q_r   <= {q_r[NW-2:0], ge};
          num_r <= num_r << 1;
          if (cnt_r == '0) begin
            state_r <= ST_SAT;
          end else begin
            cnt_r <= cnt_r - CNT_W'(1);
          end
        end
        ST_SAT: begin
          s_r     <= s_sat;
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          prod_r  <= mul_w;
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          slope_r[pair_r] <= s_r;
          icpt_r[pair_r]  <= icpt_val;
          if (pair_r == 3'(NUM_PAIRS - 1)) begin
            state_r <= ST_IDLE;
          end else begin
            pair_r  <= pair_r + 3'd1;
            state_r <= ST_SETUP;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign slope_o = slope_r;
  assign icpt_o  = icpt_r;
  assign cls_o   = cls_r;
  assign busy_o  = (state_r != ST_IDLE);

endmodule

// File: hdl/rsbo_test_pipe.sv
// ---------------------------------------------------------------------------
// rsbo_test_pipe
// Three-stage box test: select and origin tests, slope products, sign test.
// ---------------------------------------------------------------------------
module rsbo_test_pipe #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          hold_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] lo_i [3],
  input  logic signed [COORD_WIDTH-1:0] hi_i [3],
  input  logic signed [COORD_WIDTH-1:0] origin_i [3],
  input  logic signed [COORD_WIDTH-1:0] slope_i [6],
  input  logic signed [COORD_WIDTH-1:0] icpt_i [6],
  input  rsbo_pkg::axis_class_t [2:0]   cls_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          hit_o
);
  import rsbo_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int FB = FRAC_BITS;
  localparam int SW = 2 * CW + FB + 2;

  logic                   adv, accept;
  logic                   v1_r, v2_r, v3_r;
  logic                   rej1_r, rej2_r, hit3_r;
  logic [5:0]             en1_r, en2_r, ngb1_r, ngb2_r;
  logic signed [CW-1:0]   av1_r [6];
  logic signed [CW:0]     t1_r [6];
  logic signed [CW:0]     t2_r [6];
  logic signed [2*CW-1:0] prod2_r [6];

  logic                   rej1_w, rej3_w;
  logic [5:0]             en1_w, ngb1_w;
  logic signed [CW-1:0]   av1_w [6];
  logic signed [CW:0]     t1_w [6];
  logic signed [SW-1:0]   sum_w [6];

  assign adv        = !v3_r || out_ready_i;
  assign in_ready_o = adv && !hold_i;
  assign accept     = in_valid_i && in_ready_o;

  // stage 1: origin-side rejection and per-pair corner choice
  always_comb begin
    logic [1:0]         a, b;
    logic signed [CW-1:0] bv;
    rej1_w = !cls_i[0].nz && !cls_i[1].nz && !cls_i[2].nz;
    for (int k = 0; k < NUM_AXES; k++) begin
      if (!cls_i[k].nz) begin
        if (origin_i[k] < lo_i[k] || origin_i[k] > hi_i[k]) rej1_w = 1'b1;
      end else if (cls_i[k].ng) begin
        if (origin_i[k] < lo_i[k]) rej1_w = 1'b1;
      end else begin
        if (origin_i[k] > hi_i[k]) rej1_w = 1'b1;
      end
    end
    for (int p = 0; p < NUM_PAIRS; p++) begin
      a         = pair_a(3'(p));
      b         = pair_b(3'(p));
      en1_w[p]  = cls_i[a].nz && cls_i[b].nz;
      ngb1_w[p] = cls_i[b].ng;
      av1_w[p]  = cls_i[a].ng ? lo_i[a] : hi_i[a];
      bv        = cls_i[b].ng ? hi_i[b] : lo_i[b];
      t1_w[p]   = (CW+1)'(icpt_i[p]) - (CW+1)'(bv);
    end
  end

  // stage 3: slope*A/2^FB - B + c, taken exactly, tested by sign
  always_comb begin
    rej3_w = rej2_r;
    for (int p = 0; p < NUM_PAIRS; p++) begin
      sum_w[p] = SW'(prod2_r[p]) + (SW'(t2_r[p]) <<< FB);
      if (en2_r[p]) begin
        if (ngb2_r[p] ? (sum_w[p] > 0) : (sum_w[p] < 0)) rej3_w = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rej1_r <= rej1_w;
      en1_r  <= en1_w;
      ngb1_r <= ngb1_w;
      rej2_r <= rej1_r;
      en2_r  <= en1_r;
      ngb2_r <= ngb1_r;
      hit3_r <= !rej3_w;
      for (int p = 0; p < NUM_PAIRS; p++) begin
        av1_r[p]   <= av1_w[p];
        t1_r[p]    <= t1_w[p];
        prod2_r[p] <= slope_i[p] * av1_r[p];
        t2_r[p]    <= t1_r[p];
      end
    end
  end

  assign out_valid_o = v3_r;
  assign hit_o       = hit3_r;

endmodule

// File: hdl/ray_slope_box_overlap_test_top.sv
// ---------------------------------------------------------------------------
// ray_slope_box_overlap_test_top
// Ray versus axis-aligned box test by the slope method, 26 ray classes.
// ---------------------------------------------------------------------------
// The ray (origin, direction) and zero_epsilon sit in APB registers at byte
// address 4*i (8*i when COORD_WIDTH exceeds 32). Each box item gives one hit
// item. Boxes are taken one per cycle while in_ready is high, which it is not under
// output back-pressure or while the ray terms are checked or rebuilt. Each result
// passes the three register stages of the test pipeline with its six parallel
// slope multipliers. After a register write in_ready drops while the ray is
// checked for length; when it is not null the slopes and intercepts are rebuilt
// pair by pair in a shared bit-serial divider, which a pair whose denominator
// axis lies within zero_epsilon skips; no box is taken during the rebuild.
module ray_slope_box_overlap_test_top #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        psel,
  input  logic                                        penable,
  input  logic                                        pwrite,
  input  logic [((COORD_WIDTH > 32) ? 6 : 5)-1:0]     paddr,
  input  logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0]   pwdata,
  output logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0]   prdata,
  output logic                                        pready,
  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  logic signed [COORD_WIDTH-1:0]               in_box_lo_x,
  input  logic signed [COORD_WIDTH-1:0]               in_box_lo_y,
  input  logic signed [COORD_WIDTH-1:0]               in_box_lo_z,
  input  logic signed [COORD_WIDTH-1:0]               in_box_hi_x,
  input  logic signed [COORD_WIDTH-1:0]               in_box_hi_y,
  input  logic signed [COORD_WIDTH-1:0]               in_box_hi_z,
  output logic                                        out_valid,
  input  logic                                        out_ready,
  output logic                                        out_hit
);
  import rsbo_pkg::*;

  localparam int CW       = COORD_WIDTH;
  localparam int DATA_W   = (CW > 32) ? 64 : 32;
  localparam int ADDR_LSB = (CW > 32) ? 3 : 2;
  localparam int QW       = 2 * CW;

  logic signed [CW-1:0] origin_r [3];
  logic signed [CW-1:0] dir_r [3];
  logic [EPS_W-1:0]     eps_r;

  logic                 wr_en;
  reg_idx_t             idx_w;
  reg_idx_t             wr_idx_r;
  logic                 chk1_r, chk2_r;
  logic [QW-1:0]        sq_r [6];
  logic [2*EPS_W-1:0]   eps_sq_r;
  logic signed [CW-1:0] sel_w;
  logic [CW-1:0]        sel_mag;
  logic [QW+1:0]        sum_o, sum_d;
  logic                 short_o, short_d, start_w;

  logic                 der_busy;
  logic signed [CW-1:0] slope_w [6];
  logic signed [CW-1:0] icpt_w [6];
  axis_class_t [2:0]    cls_w;
  logic signed [CW-1:0] lo_w [3];
  logic signed [CW-1:0] hi_w [3];

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx_w  = reg_idx_t'(paddr[ADDR_LSB +: 3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        origin_r[k] <= '0;
        dir_r[k]    <= '0;
      end
      eps_r  <= EPS_RESET;
      chk1_r <= 1'b0;
    end else begin
      chk1_r <= 1'b0;
      if (wr_en) begin
        wr_idx_r <= idx_w;
        unique case (idx_w)
          REG_ORIGIN_X: begin origin_r[0] <= pwdata[CW-1:0]; chk1_r <= 1'b1; end
          REG_ORIGIN_Y: begin origin_r[1] <= pwdata[CW-1:0]; chk1_r <= 1'b1; end
          REG_ORIGIN_Z: begin origin_r[2] <= pwdata[CW-1:0]; chk1_r <= 1'b1; end
          REG_DIR_X:    begin dir_r[0]    <= pwdata[CW-1:0]; chk1_r <= 1'b1; end
          REG_DIR_Y:    begin dir_r[1]    <= pwdata[CW-1:0]; chk1_r <= 1'b1; end
          REG_DIR_Z:    begin dir_r[2]    <= pwdata[CW-1:0]; chk1_r <= 1'b1; end
          REG_ZERO_EPS: begin eps_r       <= pwdata[EPS_W-1:0]; chk1_r <= 1'b1; end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    unique case (idx_w)
      REG_ORIGIN_X: prdata = DATA_W'(origin_r[0]);
      REG_ORIGIN_Y: prdata = DATA_W'(origin_r[1]);
      REG_ORIGIN_Z: prdata = DATA_W'(origin_r[2]);
      REG_DIR_X:    prdata = DATA_W'(dir_r[0]);
      REG_DIR_Y:    prdata = DATA_W'(dir_r[1]);
      REG_DIR_Z:    prdata = DATA_W'(dir_r[2]);
      REG_ZERO_EPS: prdata = DATA_W'(eps_r);
      default:      prdata = '0;
    endcase
  end

  // squared lengths kept per component, refreshed one a write
  always_comb begin
    unique case (wr_idx_r)
      REG_ORIGIN_X: sel_w = origin_r[0];
      REG_ORIGIN_Y: sel_w = origin_r[1];
      REG_ORIGIN_Z: sel_w = origin_r[2];
      REG_DIR_X:    sel_w = dir_r[0];
      REG_DIR_Y:    sel_w = dir_r[1];
      REG_DIR_Z:    sel_w = dir_r[2];
      default:      sel_w = '0;
    endcase
  end
  assign sel_mag = sel_w[CW-1] ? (CW'(0) - sel_w) : sel_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 6; k++) sq_r[k] <= '0;
      chk2_r <= 1'b0;
    end else begin
      chk2_r <= chk1_r;
      if (chk1_r && wr_idx_r != REG_ZERO_EPS) begin
        sq_r[3'(wr_idx_r)] <= QW'(sel_mag) * QW'(sel_mag);
      end
    end
  end

  always_ff @(posedge clk) begin
    eps_sq_r <= eps_r * eps_r;
  end

  assign sum_o   = (QW+2)'(sq_r[0]) + (QW+2)'(sq_r[1]) + (QW+2)'(sq_r[2]);
  assign sum_d   = (QW+2)'(sq_r[3]) + (QW+2)'(sq_r[4]) + (QW+2)'(sq_r[5]);
  assign short_o = (sum_o == '0) || (sum_o < (QW+2)'(eps_sq_r));
  assign short_d = (sum_d == '0) || (sum_d < (QW+2)'(eps_sq_r));
  // a null ray leaves the derived terms as they are
  assign start_w = chk2_r && !(short_o && short_d);

  rsbo_derive #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_derive (
    .clk      (clk),
    .rst_n    (rst_n),
    .start_i  (start_w),
    .origin_i (origin_r),
    .dir_i    (dir_r),
    .eps_i    (eps_r),
    .slope_o  (slope_w),
    .icpt_o   (icpt_w),
    .cls_o    (cls_w),
    .busy_o   (der_busy)
  );

  assign lo_w[0] = in_box_lo_x;
  assign lo_w[1] = in_box_lo_y;
  assign lo_w[2] = in_box_lo_z;
  assign hi_w[0] = in_box_hi_x;
  assign hi_w[1] = in_box_hi_y;
  assign hi_w[2] = in_box_hi_z;

  rsbo_test_pipe #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_pipe (
    .clk         (clk),
    .rst_n       (rst_n),
    .hold_i      (chk1_r || chk2_r || der_busy),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .lo_i        (lo_w),
    .hi_i        (hi_w),
    .origin_i    (origin_r),
    .slope_i     (slope_w),
    .icpt_i      (icpt_w),
    .cls_i       (cls_w),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .hit_o       (out_hit)
  );

endmodule

// File: hdl/rsbo_checker.sv
// ---------------------------------------------------------------------------
// rsbo_checker
// Port-level checks on the ray slope box test block, bound to the top level.
// ---------------------------------------------------------------------------
`include "ray_slope_box_overlap_test_top_macros.svh"

module rsbo_checker #(
  parameter int COORD_WIDTH = 32
) (
  input logic                                      clk,
  input logic                                      rst_n,
  input logic                                      psel,
  input logic                                      penable,
  input logic                                      pwrite,
  input logic [((COORD_WIDTH > 32) ? 6 : 5)-1:0]   paddr,
  input logic                                      pready,
  input logic                                      in_ready,
  input logic                                      out_valid,
  input logic                                      out_ready,
  input logic                                      out_hit
);
  import rsbo_pkg::*;

  localparam int ADDR_LSB = (COORD_WIDTH > 32) ? 3 : 2;

  logic reg_wr;
  assign reg_wr = psel && penable && pwrite && pready &&
                  (paddr[ADDR_LSB +: 3] < 3'(NUM_REGS));

  // a held result keeps its value
  `RSBO_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_hit), "result changed while stalled")

  // reset empties the pipeline
  `RSBO_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid, "result item after reset")

  // in_ready stays low while a register write is checked for ray length
  `RSBO_ASSERT(a_cfg_block, reg_wr |=> !in_ready ##1 !in_ready, "box accepted during ray update")

endmodule

bind ray_slope_box_overlap_test_top rsbo_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_rsbo_checker (.*);

// File: tb/tb_ray_slope_box_overlap_test_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_ray_slope_box_overlap_test_top
// Self-checking bench for the ray slope box overlap test.
// ---------------------------------------------------------------------------
// Rays are loaded over the APB port while the block is idle; a local ray
// model rebuilds slopes, intercepts and the sign class after every write and
// predicts the hit bit of each accepted box. Boxes are mostly placed around
// points on the ray, with full random and degenerate boxes mixed in.
module tb_ray_slope_box_overlap_test_top;
  import rsbo_pkg::*;

  typedef logic signed [127:0] wide_t;
  typedef struct {
    logic [31:0] lo [3];
    logic [31:0] hi [3];
  } box_t;

  localparam int AXIS_A [6] = '{0, 0, 1, 1, 2, 2};
  localparam int AXIS_B [6] = '{1, 2, 0, 2, 0, 1};

  logic        clk;
  logic        rst_n;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        in_valid, in_ready;
  logic signed [31:0] in_box_lo_x, in_box_lo_y, in_box_lo_z;
  logic signed [31:0] in_box_hi_x, in_box_hi_y, in_box_hi_z;
  logic        out_valid, out_ready, out_hit;

  ray_slope_box_overlap_test_top dut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_box_lo_x(in_box_lo_x), .in_box_lo_y(in_box_lo_y), .in_box_lo_z(in_box_lo_z),
    .in_box_hi_x(in_box_hi_x), .in_box_hi_y(in_box_hi_y), .in_box_hi_z(in_box_hi_z),
    .out_valid(out_valid), .out_ready(out_ready), .out_hit(out_hit)
  );

  // ray model state
  longint      ray_org [3];
  longint      ray_dir [3];
  longint      zero_eps;
  longint      slope_tab [6];
  longint      icpt_tab [6];
  axis_class_t axis_cls [3];

  box_t pending_boxes [$];
  bit   expected_hits [$];
  box_t cur_box;
  int   errors;
  int   hits_seen;
  bit   gaps_on;
  int   stall_cycles;
  bit   stall_done;

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  function automatic longint sat32(wide_t v);
    if (v > 128'sd2147483647) return 64'sd2147483647;
    if (v < -128'sd2147483648) return -64'sd2147483648;
    return longint'(v);
  endfunction

  function automatic bit near_zero(longint v);
    return v == 0 || (v < 0 ? -v : v) < zero_eps;
  endfunction

  function automatic bit short_vec(longint v0, longint v1, longint v2);
    wide_t s, e;
    s = wide_t'(v0) * wide_t'(v0) + wide_t'(v1) * wide_t'(v1) + wide_t'(v2) * wide_t'(v2);
    e = wide_t'(zero_eps) * wide_t'(zero_eps);
    return s == 0 || s < e;
  endfunction

  task automatic rebuild_ray();
    wide_t num, den, c;
    longint s;
    int a, b;
    if (short_vec(ray_org[0], ray_org[1], ray_org[2]) &&
        short_vec(ray_dir[0], ray_dir[1], ray_dir[2]))
      return;
    for (int p = 0; p < 6; p++) begin
      a = AXIS_A[p];
      b = AXIS_B[p];
      if (near_zero(ray_dir[a])) begin
        s = 0;
      end else begin
        num = wide_t'(ray_dir[b]) <<< 16;
        den = wide_t'(ray_dir[a]);
        s = sat32(num / den);
      end
      c = (wide_t'(ray_org[b]) <<< 16) - wide_t'(s) * wide_t'(ray_org[a]);
      slope_tab[p] = s;
      icpt_tab[p]  = sat32(c >>> 16);
    end
    for (int k = 0; k < 3; k++) begin
      axis_cls[k].nz = !near_zero(ray_dir[k]);
      axis_cls[k].ng = axis_cls[k].nz && ray_dir[k] < 0;
    end
  endtask

  function automatic bit box_hit(box_t bx);
    longint lo [3];
    longint hi [3];
    longint av, bv;
    wide_t s;
    bit rej;
    int a, b;
    rej = !(axis_cls[0].nz || axis_cls[1].nz || axis_cls[2].nz);
    for (int k = 0; k < 3; k++) begin
      lo[k] = longint'($signed(bx.lo[k]));
      hi[k] = longint'($signed(bx.hi[k]));
      if (!axis_cls[k].nz) begin
        if (ray_org[k] < lo[k] || ray_org[k] > hi[k]) rej = 1;
      end else if (axis_cls[k].ng) begin
        if (ray_org[k] < lo[k]) rej = 1;
      end else if (ray_org[k] > hi[k]) begin
        rej = 1;
      end
    end
    for (int p = 0; p < 6; p++) begin
      a = AXIS_A[p];
      b = AXIS_B[p];
      if (axis_cls[a].nz && axis_cls[b].nz) begin
        av = axis_cls[a].ng ? lo[a] : hi[a];
        bv = axis_cls[b].ng ? hi[b] : lo[b];
        s = wide_t'(slope_tab[p]) * wide_t'(av) +
            ((wide_t'(icpt_tab[p]) - wide_t'(bv)) <<< 16);
        if (axis_cls[b].ng ? (s > 0) : (s < 0)) rej = 1;
      end
    end
    return !rej;
  endfunction

  // box driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) expected_hits.push_back(box_hit(cur_box));
      if (pending_boxes.size() > 0 && !(gaps_on && $urandom_range(0, 99) < 20)) begin
        cur_box = pending_boxes.pop_front();
        in_box_lo_x <= cur_box.lo[0];
        in_box_lo_y <= cur_box.lo[1];
        in_box_lo_z <= cur_box.lo[2];
        in_box_hi_x <= cur_box.hi[0];
        in_box_hi_y <= cur_box.hi[1];
        in_box_hi_z <= cur_box.hi[2];
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // hit monitor, with one long hold-off once traffic is flowing
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_hits.size() == 0) begin
          $display("%0t: unexpected hit item, actual %0b", $time, out_hit);
          errors++;
        end else begin
          bit exp_hit;
          exp_hit = expected_hits.pop_front();
          if (out_hit !== exp_hit) begin
            $display("%0t: hit mismatch, expected %0b actual %0b", $time, exp_hit, out_hit);
            errors++;
          end
        end
        hits_seen++;
      end
      if (stall_cycles > 0) begin
        stall_cycles--;
        out_ready <= 1'b0;
      end else if (!stall_done && hits_seen >= 400) begin
        stall_done = 1;
        stall_cycles = 150;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(gaps_on && $urandom_range(0, 99) < 20);
      end
    end
  end

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_boxes.size() > 0 || in_valid || expected_hits.size() > 0);
  endtask

  task automatic cfg_write(reg_idx_t r, logic [31:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (r)
      REG_ORIGIN_X: ray_org[0] = longint'($signed(v));
      REG_ORIGIN_Y: ray_org[1] = longint'($signed(v));
      REG_ORIGIN_Z: ray_org[2] = longint'($signed(v));
      REG_DIR_X:    ray_dir[0] = longint'($signed(v));
      REG_DIR_Y:    ray_dir[1] = longint'($signed(v));
      REG_DIR_Z:    ray_dir[2] = longint'($signed(v));
      default:      zero_eps   = longint'(v[15:0]);
    endcase
    rebuild_ray();
    // block rebuilds its tables before taking the next box
    repeat (3) @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic load_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                          logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                          logic [15:0] e);
    wait_idle();
    cfg_write(REG_ZERO_EPS, {16'd0, e});
    cfg_write(REG_ORIGIN_X, ox);
    cfg_write(REG_ORIGIN_Y, oy);
    cfg_write(REG_ORIGIN_Z, oz);
    cfg_write(REG_DIR_X, dx);
    cfg_write(REG_DIR_Y, dy);
    cfg_write(REG_DIR_Z, dz);
  endtask

  task automatic push_box(logic [31:0] lx, logic [31:0] ly, logic [31:0] lz,
                          logic [31:0] hx, logic [31:0] hy, logic [31:0] hz);
    box_t bx;
    bx.lo = '{lx, ly, lz};
    bx.hi = '{hx, hy, hz};
    pending_boxes.push_back(bx);
  endtask

  function automatic logic [31:0] rand_dir_comp();
    longint m;
    case ($urandom_range(0, 2))
      0: return ($urandom_range(0, 1) || zero_eps < 2) ? 32'd0
                : 32'($urandom_range(0, int'(zero_eps) - 1)) * ($urandom_range(0, 1) ? 1 : -1);
      default: begin
        m = $urandom_range(0, 9) == 0 ? longint'($urandom_range(1, 32'h7fffffff))
                                      : longint'($urandom_range(1 << 12, 1 << 20));
        return $urandom_range(0, 1) ? 32'(m) : 32'(-m);
      end
    endcase
  endfunction

  // mostly boxes around a point on the ray, some noise and inverted boxes
  task automatic push_random_box();
    box_t bx;
    longint pt, t;
    int kind;
    kind = $urandom_range(0, 99);
    t = $urandom_range(0, 1 << 20);
    for (int k = 0; k < 3; k++) begin
      if (kind < 15) begin
        bx.lo[k] = $urandom;
        bx.hi[k] = $urandom;
      end else begin
        pt = ray_org[k] + ((ray_dir[k] * t) >>> 16);
        bx.lo[k] = 32'(pt - longint'($urandom_range(0, 1 << 18)));
        bx.hi[k] = 32'(pt + longint'($urandom_range(0, 1 << 18)));
        if (kind >= 95) {bx.lo[k], bx.hi[k]} = {bx.hi[k], bx.lo[k]};
      end
    end
    pending_boxes.push_back(bx);
  endtask

  initial begin
    rst_n    = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    in_box_lo_x = '0; in_box_lo_y = '0; in_box_lo_z = '0;
    in_box_hi_x = '0; in_box_hi_y = '0; in_box_hi_z = '0;
    errors = 0; hits_seen = 0; gaps_on = 1; stall_cycles = 0; stall_done = 0;
    for (int k = 0; k < 3; k++) begin
      ray_org[k] = 0; ray_dir[k] = 0;
      axis_cls[k] = '0;
    end
    for (int p = 0; p < 6; p++) begin
      slope_tab[p] = 0; icpt_tab[p] = 0;
    end
    zero_eps = 1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset ray has a zero direction: everything misses
    push_box(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    push_box(0, 0, 0, 0, 0, 0);

    // extreme ray, all axes moving
    load_ray(32'h7fffffff, 32'h80000000, 0, 32'h80000000, 32'h7fffffff, 32'h00000001, 16'd0);
    push_box(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    push_box(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000);
    push_box(0, 0, 0, 0, 0, 0);
    push_box(32'hffffffff, 32'h00010000, 32'h00000000, 32'h00010000, 32'h7fff0000, 32'h00020000);

    // one axis inside epsilon, largest epsilon
    load_ray(32'h00010000, 32'h00020000, 32'h00030000, 32'h00010000, 32'h0000fffe,
             32'hffff0000, 16'hffff);
    push_box(0, 0, 0, 32'h00040000, 32'h00040000, 32'h00040000);
    push_box(0, 32'h00030000, 0, 32'h00040000, 32'h00040000, 32'h00040000);
    push_box(32'h00040000, 32'h00010000, 32'h00010000, 32'h00020000, 32'h00030000, 32'h00020000);

    // null ray: derived terms keep their last values
    load_ray(0, 0, 0, 0, 0, 0, 16'd1);
    push_box(32'hffff0000, 32'hffff0000, 32'hffff0000, 32'h00010000, 32'h00010000,
             32'h00010000);
    push_box(0, 0, 0, 0, 0, 0);
    wait_idle();

    for (int ph = 0; ph < 18; ph++) begin
      logic [15:0] e;
      case (ph % 6)
        0: e = 16'd0;
        1: e = 16'hffff;
        default: e = 16'($urandom_range(1, 4096));
      endcase
      zero_eps = e;
      gaps_on = (ph != 5);
      load_ray(32'($signed($urandom_range(0, 1 << 23)) - (1 << 22)),
               32'($signed($urandom_range(0, 1 << 23)) - (1 << 22)),
               32'($signed($urandom_range(0, 1 << 23)) - (1 << 22)),
               rand_dir_comp(), rand_dir_comp(), rand_dir_comp(), e);
      repeat (100) push_random_box();
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/rsbo_pkg.sv
hdl/rsbo_derive.sv
hdl/rsbo_test_pipe.sv
hdl/ray_slope_box_overlap_test_top.sv
hdl/rsbo_checker.sv
tb/tb_ray_slope_box_overlap_test_top.sv
